// ===== src/lhist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log2 latency histogram package
// Shared constants, beat types and counter helpers for the histogram block.
// ----------------------------------------------------------------------------
package lhist_pkg;

  // Histogram geometry and counter width.
  localparam int NUM_BINS      = 48;
  localparam int NUM_METRICS   = 3;
  localparam int COUNTER_WIDTH = 32;

  // Fixed field widths of the beats.
  localparam int OUT_WIDTH   = 32;
  localparam int BUCKET_W    = 6;
  localparam int METRIC_W    = 2;
  localparam int DELTA_W     = 64;

  // Bin memory geometry.
  localparam int MEM_DEPTH = NUM_METRICS * NUM_BINS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int MIDX_W    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;

  // Highest bin index, at the width of the bucket field.
  localparam logic [BUCKET_W-1:0] LAST_BIN = BUCKET_W'(NUM_BINS - 1);

  // Request type codes.
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  // Request beat.
  typedef struct packed {
    logic                       req_type;
    logic [METRIC_W-1:0]        metric;
    logic signed [DELTA_W-1:0]  delta_ns;
    logic [BUCKET_W-1:0]        read_bin;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic                  accepted;
    logic [BUCKET_W-1:0]   bucket;
    logic [OUT_WIDTH-1:0]  bin_value;
    logic [OUT_WIDTH-1:0]  count_value;
  } rsp_t;

  // Bin memory read and write controls.
  typedef struct packed {
    logic  en;
    addr_t addr;
  } mem_rd_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    cnt_t  data;
  } mem_wr_t;

  // Saturating increment of a counter.
  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // Report a counter on a 32-bit field, saturating wider values.
  function automatic logic [OUT_WIDTH-1:0] to_out(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'h0000_0000_FFFF_FFFF) begin
      return '1;
    end
    return w[OUT_WIDTH-1:0];
  endfunction

endpackage

// ===== src/lhist_bucket.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log2 bucket unit
// Splits the 64-bit delta into eight byte groups, registers a leading-one
// position per group, then combines the groups into a clamped bin index.
// ----------------------------------------------------------------------------
module lhist_bucket (
  input  logic                             clk,
  input  logic                             load,
  input  logic [lhist_pkg::DELTA_W-1:0]    delta,
  output logic [lhist_pkg::BUCKET_W-1:0]   bucket
);
  import lhist_pkg::*;

  localparam int GROUPS  = 8;
  localparam int GROUP_W = DELTA_W / GROUPS;

  logic [GROUPS-1:0] any;
  logic [2:0]        pos [GROUPS];
  logic [GROUPS-1:0] any_next;
  logic [2:0]        pos_next [GROUPS];

  // Leading-one position inside each byte; the groups are independent.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      any_next[g] = 1'b0;
      pos_next[g] = '0;
      for (int i = 0; i < GROUP_W; i++) begin
        if (delta[g*GROUP_W + i]) begin
          any_next[g] = 1'b1;
          pos_next[g] = 3'(i);
        end
      end
    end
  end

  // First stage registers, loaded when a request beat is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      any <= any_next;
      for (int g = 0; g < GROUPS; g++) begin
        pos[g] <= pos_next[g];
      end
    end
  end

  // Highest non-empty group gives the top bits; zero and one land in bin 0.
  logic [BUCKET_W-1:0] raw;
  always_comb begin
    raw = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (any[g]) begin
        raw = {3'(g), pos[g]};
      end
    end
    bucket = (raw > LAST_BIN) ? LAST_BIN : raw;
  end

endmodule

// ===== src/lhist_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin counter memory
// One read and one write port with registered read data. A valid bit per
// entry, cleared by reset, makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
module lhist_mem (
  input  logic               clk,
  input  logic               rst,
  input  lhist_pkg::mem_rd_t rd,
  input  lhist_pkg::mem_wr_t wr,
  output lhist_pkg::cnt_t    rd_data
);
  import lhist_pkg::*;

  cnt_t                 mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid;
  cnt_t                 data_q;
  logic                 valid_q;

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      data_q <= mem[rd.addr];
    end
  end

  // Entry valid bits and the valid flag of the read beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        valid_q <= valid[rd.addr];
      end
    end
  end

  assign rd_data = valid_q ? data_q : '0;

endmodule

// ===== src/log2_latency_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log2 latency histogram
// Per-metric logarithmic latency histograms with saturating counters.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one beat per request: a record beat bins a
//   non-negative nanosecond delta by floor(log2) (clamped to the last bin)
//   and bumps that bin and the metric total; a read beat returns one bin and
//   the metric total. Every request beat yields exactly one rsp beat.
//   A beat moves when valid is high and stall is low.
//   A request that touches the bin memory goes through accept, memory
//   read, read-modify-write of the bin and the metric total, and hand-off
//   to the output register. A dropped sample or an out-of-range metric
//   skips the memory read and the modify step. Only one request is in
//   flight, so the next one can be taken in the cycle after the hand-off.
//   The output register holds a finished response while the receiver
//   stalls; a further request can then be worked up to the hand-off, where
//   it waits for the output register to drain.
//   Reset clears all bins (through per-entry valid bits) and the metric
//   totals; req is stalled while reset is high.
// ----------------------------------------------------------------------------
module log2_latency_histogram (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lhist_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output lhist_pkg::rsp_t rsp
);
  import lhist_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INDEX,
    S_MODIFY,
    S_DONE
  } state_t;

  state_t              state;
  req_t                req_q;
  rsp_t                res_q;
  logic [BUCKET_W-1:0] bin_q;
  addr_t               addr_q;
  cnt_t                totals [NUM_METRICS];

  logic                req_take;
  logic                out_free;
  logic [BUCKET_W-1:0] bucket;
  logic [MIDX_W-1:0]   midx;
  logic                metric_ok;
  logic                is_rec;
  logic [BUCKET_W-1:0] rd_bin;
  logic [BUCKET_W-1:0] sel_bin;
  addr_t               addr;
  cnt_t                total_old;
  cnt_t                bin_old;
  cnt_t                bin_new;
  cnt_t                total_new;
  mem_rd_t             mem_rd;
  mem_wr_t             mem_wr;

  assign req_stall = rst || (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Bin index from the delta.
  lhist_bucket u_bucket (
    .clk    (clk),
    .load   (req_take),
    .delta  (req.delta_ns),
    .bucket (bucket)
  );

  // Request decode and bin address.
  always_comb begin
    midx      = MIDX_W'(req_q.metric);
    metric_ok = 32'(req_q.metric) < NUM_METRICS;
    is_rec    = req_q.req_type == REQ_RECORD;
    rd_bin    = (req_q.read_bin > LAST_BIN) ? LAST_BIN : req_q.read_bin;
    sel_bin   = is_rec ? bucket : rd_bin;
    addr      = addr_t'(midx) * addr_t'(NUM_BINS) + addr_t'(sel_bin);
    total_old = metric_ok ? totals[midx] : '0;
  end

  // Modify step: increment on a record, pass through on a read.
  always_comb begin
    bin_new   = is_rec ? sat_inc(bin_old) : bin_old;
    total_new = is_rec ? sat_inc(total_old) : total_old;
  end

  // Bin memory ports.
  always_comb begin
    mem_rd.en   = (state == S_INDEX) && metric_ok && !(is_rec && req_q.delta_ns[DELTA_W-1]);
    mem_rd.addr = addr;
    mem_wr.en   = (state == S_MODIFY) && is_rec;
    mem_wr.addr = addr_q;
    mem_wr.data = bin_new;
  end

  lhist_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd      (mem_rd),
    .wr      (mem_wr),
    .rd_data (bin_old)
  );

  // Request and result holding registers.
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q <= req;
    end
    if (state == S_INDEX) begin
      bin_q  <= sel_bin;
      addr_q <= addr;
      // Only the total is reported here; it reads as zero for a bad metric.
      res_q <= '{accepted: 1'b0, bucket: '0, bin_value: '0,
                 count_value: to_out(total_old)};
    end
    if (state == S_MODIFY) begin
      res_q <= '{accepted: is_rec, bucket: bin_q, bin_value: to_out(bin_new),
                 count_value: to_out(total_new)};
    end
  end

  // Sequencer, metric totals and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int m = 0; m < NUM_METRICS; m++) begin
        totals[m] <= '0;
      end
    end else begin
      // Load a finished beat, or drop the one the receiver has taken.
      if ((state == S_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            state <= S_INDEX;
          end
        end
        S_INDEX: begin
          if (mem_rd.en) begin
            state <= S_MODIFY;
          end else begin
            state <= S_DONE;
          end
        end
        S_MODIFY: begin
          if (is_rec) begin
            totals[midx] <= total_new;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp   <= res_q;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lhist_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log2 latency histogram checker
// Port-level properties of the histogram, bound to the top level.
// ----------------------------------------------------------------------------
module lhist_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input lhist_pkg::rsp_t rsp
);
  import lhist_pkg::*;

  // A stalled response beat holds.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // Requests are worked one at a time: a taken beat stalls the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in flight");

  // A response never names a bin beyond the last one.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.bucket <= LAST_BIN)
    else $error("response bucket out of range");

  // A recorded sample leaves its bin and the metric total nonzero, and the
  // reported total is not below the reported bin.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.accepted |->
      rsp.bin_value != '0 && rsp.count_value >= rsp.bin_value)
    else $error("record response counts inconsistent");

endmodule

bind log2_latency_histogram lhist_checker u_lhist_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
